[hdl/sorted_multiset_difference_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted multiset difference core
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTISET_DIFFERENCE_CORE_ASSERT_SVH
`define SORTED_MULTISET_DIFFERENCE_CORE_ASSERT_SVH

// Same-cycle implication
`define SMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/smd_pkg.sv]
// ----------------------------------------------------------------------------
// smd_pkg
// Sizes and request codes for the sorted multiset difference core.
// ----------------------------------------------------------------------------
`default_nettype none

package smd_pkg;

  localparam int DEPTH_A     = 64;
  localparam int DEPTH_B     = 64;
  localparam int VALUE_WIDTH = 32;

  // Field widths on the ports
  localparam int DATA_W = 32;
  localparam int REQ_W  = 2;

  // Pointer/count widths hold 0..DEPTH inclusive
  localparam int CNT_A_W = $clog2(DEPTH_A + 1);
  localparam int CNT_B_W = $clog2(DEPTH_B + 1);

  // Memory address widths
  localparam int ADDR_A_W = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int ADDR_B_W = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;

  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;

endpackage

`default_nettype wire

[hdl/smd_ram.sv]
// ----------------------------------------------------------------------------
// smd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/sorted_multiset_difference_core.sv]
// ----------------------------------------------------------------------------
// sorted_multiset_difference_core
// Loads two sorted lists and streams A minus B (multiset) on a run command.
// ----------------------------------------------------------------------------
// A load beat (tuser 0 for A, 1 for B) writes one element; a load into a full
// list is dropped and flagged on the next run's results. A run beat (tuser 2)
// walks both list memories with one read pointer each, one merge step per
// cycle, though a step that must emit waits while the result side stalls;
// each list memory has one read port. The input side is held off while a run
// is in progress. Each result is held one step so the final one can carry
// tlast; an empty difference gives a single beat flagged empty with data zero.
// A run clears both counts and the overflow flag. Request code 3 is accepted
// and ignored.
`default_nettype none

`include "sorted_multiset_difference_core_assert.svh"

module sorted_multiset_difference_core
  import smd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [DATA_W-1:0] in_tdata,   // [31:0] value
  input  wire logic [REQ_W-1:0]  in_tuser,   // [1:0] req_type
  // result channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [DATA_W-1:0] out_tdata,  // [31:0] diff_value
  output logic                   out_tlast,  // is_last
  output logic      [1:0]        out_tuser   // [0] empty_result, [1] load_overflow
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_A_W-1:0]     count_a_r, count_a_nxt;
  logic [CNT_B_W-1:0]     count_b_r, count_b_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [CNT_A_W-1:0]     ptr_a_r, ptr_a_nxt;
  logic [CNT_B_W-1:0]     ptr_b_r, ptr_b_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic [VALUE_WIDTH-1:0] pend_value_r, pend_value_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]      out_value_r, out_value_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_empty_r, out_empty_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                   we_a, we_b;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata_a, rdata_b;
  logic                   a_done, b_done, can_emit;
  logic                   push, push_last, push_empty;
  logic [VALUE_WIDTH-1:0] push_value;

  assign wdata = VALUE_WIDTH'(in_tdata);

  smd_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH_A)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a_r[ADDR_A_W-1:0]),
    .wdata (wdata),
    .raddr (ptr_a_nxt[ADDR_A_W-1:0]),
    .rdata (rdata_a)
  );

  smd_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH_B)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b_r[ADDR_B_W-1:0]),
    .wdata (wdata),
    .raddr (ptr_b_nxt[ADDR_B_W-1:0]),
    .rdata (rdata_b)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign a_done    = (ptr_a_r == count_a_r);
  assign b_done    = (ptr_b_r == count_b_r);
  assign can_emit  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    count_a_nxt    = count_a_r;
    count_b_nxt    = count_b_r;
    ovf_nxt        = ovf_r;
    ptr_a_nxt      = ptr_a_r;
    ptr_b_nxt      = ptr_b_r;
    pend_valid_nxt = pend_valid_r;
    pend_value_nxt = pend_value_r;
    we_a           = 1'b0;
    we_b           = 1'b0;
    push           = 1'b0;
    push_last      = 1'b0;
    push_empty     = 1'b0;
    push_value     = pend_value_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            REQ_LOAD_A: begin
              if (count_a_r != CNT_A_W'(DEPTH_A)) begin
                we_a        = 1'b1;
                count_a_nxt = count_a_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            REQ_LOAD_B: begin
              if (count_b_r != CNT_B_W'(DEPTH_B)) begin
                we_b        = 1'b1;
                count_b_nxt = count_b_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            REQ_RUN: begin
              state_nxt = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // rdata_a/rdata_b hold A[ptr_a_r] and B[ptr_b_r]
        priority if (a_done) begin
          if (can_emit) begin
            push           = 1'b1;
            push_last      = 1'b1;
            push_empty     = !pend_valid_r;
            push_value     = pend_valid_r ? pend_value_r : '0;
            state_nxt      = ST_IDLE;
            count_a_nxt    = '0;
            count_b_nxt    = '0;
            ovf_nxt        = 1'b0;
            ptr_a_nxt      = '0;
            ptr_b_nxt      = '0;
            pend_valid_nxt = 1'b0;
          end
        end else if (!b_done && rdata_a == rdata_b) begin
          ptr_a_nxt = ptr_a_r + 1'b1;
          ptr_b_nxt = ptr_b_r + 1'b1;
        end else if (b_done || $signed(rdata_a) < $signed(rdata_b)) begin
          // emit A; the held result goes out first
          if (!pend_valid_r || can_emit) begin
            push           = pend_valid_r;
            pend_valid_nxt = 1'b1;
            pend_value_nxt = rdata_a;
            ptr_a_nxt      = ptr_a_r + 1'b1;
          end
        end else begin
          ptr_b_nxt = ptr_b_r + 1'b1;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = DATA_W'(push_value);
      out_last_nxt  = push_last;
      out_empty_nxt = push_empty;
      out_ovf_nxt   = ovf_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_a_r    <= '0;
      count_b_r    <= '0;
      ovf_r        <= 1'b0;
      ptr_a_r      <= '0;
      ptr_b_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_a_r    <= count_a_nxt;
      count_b_r    <= count_b_nxt;
      ovf_r        <= ovf_nxt;
      ptr_a_r      <= ptr_a_nxt;
      ptr_b_r      <= ptr_b_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_value_r <= pend_value_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_empty_r  <= out_empty_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};

  `SMD_ASSERT_NOW(a_ptr_in_range, 1'b1, ptr_a_r <= count_a_r && ptr_b_r <= count_b_r,
    "read pointer beyond list count")
  `SMD_ASSERT_NOW(count_in_range,
    1'b1, count_a_r <= CNT_A_W'(DEPTH_A) && count_b_r <= CNT_B_W'(DEPTH_B),
    "list count beyond depth")
  `SMD_ASSERT_NOW(idle_no_pending, state_r == ST_IDLE,
    !pend_valid_r && ptr_a_r == '0 && ptr_b_r == '0, "idle with run state left over")
  `SMD_ASSERT_NEXT(run_ends_clean, state_r == ST_RUN && state_nxt == ST_IDLE,
    out_tvalid && out_tlast && count_a_r == '0 && count_b_r == '0 && !ovf_r,
    "run finished without a last beat or cleared counts")

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives load and run beats into the sorted multiset difference core. A
// scoreboard works out each run's difference from the loaded lists and checks
// every result beat in order. Both sides stall at random, and the result side
// is held off once for a long stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module tb;
  import smd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = DEPTH_A + DEPTH_B + 30;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              empty;
    logic              ovf;
  } diff_beat_t;

  class diff_scoreboard;
    logic signed [VALUE_WIDTH-1:0] list_a [DEPTH_A];
    logic signed [VALUE_WIDTH-1:0] list_b [DEPTH_B];
    int unsigned count_a;
    int unsigned count_b;
    bit          overflow_seen;
    diff_beat_t  pending_diffs[$];
    int          mismatches;

    task report_mismatch(input string msg);
      $display("[tb] %0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void push_diff(input logic signed [VALUE_WIDTH-1:0] v, input logic empty);
      diff_beat_t b;
      b.value = DATA_W'(v);
      b.last  = 1'b0;
      b.empty = empty;
      b.ovf   = overflow_seen;
      pending_diffs.push_back(b);
    endfunction

    function void note_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] data);
      int unsigned ia;
      int unsigned ib;
      int          emitted;
      case (req)
        REQ_LOAD_A: begin
          if (count_a < DEPTH_A) begin
            list_a[count_a] = data[VALUE_WIDTH-1:0];
            count_a++;
          end else begin
            overflow_seen = 1'b1;
          end
        end
        REQ_LOAD_B: begin
          if (count_b < DEPTH_B) begin
            list_b[count_b] = data[VALUE_WIDTH-1:0];
            count_b++;
          end else begin
            overflow_seen = 1'b1;
          end
        end
        REQ_RUN: begin
          ia = 0;
          ib = 0;
          emitted = 0;
          // equal cancels one of each, smaller A survives, smaller B is skipped
          while (ia < count_a && ib < count_b) begin
            if (list_a[ia] == list_b[ib]) begin
              ia++;
              ib++;
            end else if (list_a[ia] < list_b[ib]) begin
              push_diff(list_a[ia], 1'b0);
              emitted++;
              ia++;
            end else begin
              ib++;
            end
          end
          while (ia < count_a) begin
            push_diff(list_a[ia], 1'b0);
            emitted++;
            ia++;
          end
          if (emitted == 0)
            push_diff('0, 1'b1);
          pending_diffs[pending_diffs.size()-1].last = 1'b1;
          count_a = 0;
          count_b = 0;
          overflow_seen = 1'b0;
        end
        default: ;
      endcase
    endfunction

    task check_result(input logic [DATA_W-1:0] value, input logic last,
                      input logic empty, input logic ovf);
      diff_beat_t want;
      if (pending_diffs.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data %h last %b", value, last));
        return;
      end
      want = pending_diffs.pop_front();
      if (value !== want.value)
        report_mismatch($sformatf("diff_value %h, want %h", value, want.value));
      if (last !== want.last)
        report_mismatch($sformatf("is_last %b, want %b", last, want.last));
      if (empty !== want.empty)
        report_mismatch($sformatf("empty_result %b, want %b", empty, want.empty));
      if (ovf !== want.ovf)
        report_mismatch($sformatf("load_overflow %b, want %b", ovf, want.ovf));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;   // [31:0] value
  logic [REQ_W-1:0]  in_tuser;   // [1:0] req_type
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;  // [31:0] diff_value
  logic              out_tlast;  // is_last
  logic [1:0]        out_tuser;  // [0] empty_result, [1] load_overflow

  diff_scoreboard sb = new();

  bit idle_on;
  bit stall_on;
  int hold_req   = 0;
  int hold_seen  = 0;
  int stall_left = 0;
  int items_sent;

  sorted_multiset_difference_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[sorted_multiset_difference_core] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tlast, out_tuser[0], out_tuser[1]);
    end
  end

  // result side: random short stalls, or one long hold when asked
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      stall_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // called and returns at a falling edge; valid stays up for a back-to-back beat
  task automatic send_beat(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (req != REQ_UNUSED)
      items_sent++;
  endtask

  task automatic load_and_run(input int n_a, input int n_b, input bit unsorted,
                              input bit hold_results);
    int qa[$];
    int qb[$];
    int base;
    int k;
    bit narrow;
    narrow = $urandom_range(0, 2) != 0;
    case ($urandom_range(0, 3))
      0:       base = 32'h8000_0000;
      1:       base = 32'h7fff_fff0;
      2:       base = -8;
      default: base = $urandom();
    endcase
    for (k = 0; k < n_a; k++)
      qa.push_back(narrow ? base + $urandom_range(0, 15) : $urandom());
    // half of B is drawn from A so that cancellations are common
    for (k = 0; k < n_b; k++) begin
      if (qa.size() != 0 && $urandom_range(0, 1))
        qb.push_back(qa[$urandom_range(0, qa.size() - 1)]);
      else
        qb.push_back(narrow ? base + $urandom_range(0, 15) : $urandom());
    end
    if (!unsorted) begin
      qa.sort();
      qb.sort();
    end
    while (qa.size() + qb.size() != 0) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(REQ_UNUSED, $urandom());
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1)))
        send_beat(REQ_LOAD_A, qa.pop_front());
      else
        send_beat(REQ_LOAD_B, qb.pop_front());
    end
    if (hold_results) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      hold_req++;
      @(negedge clk);
    end
    send_beat(REQ_RUN, $urandom());
  endtask

  initial begin
    int seq_no;
    int waited;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_LOAD_A;
    idle_on    = 1'b1;
    stall_on   = 1'b1;
    items_sent = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // both lists empty
    send_beat(REQ_RUN, 32'hffff_ffff);
    send_beat(REQ_UNUSED, 32'hffff_ffff);
    // extremes of the value range
    send_beat(REQ_LOAD_A, 32'h8000_0000);
    send_beat(REQ_LOAD_A, 32'hffff_ffff);
    send_beat(REQ_LOAD_A, 32'h0000_0000);
    send_beat(REQ_LOAD_A, 32'h7fff_ffff);
    send_beat(REQ_LOAD_B, 32'hffff_ffff);
    send_beat(REQ_LOAD_B, 32'h7fff_ffff);
    send_beat(REQ_RUN, 32'h0);
    // duplicates in A, one cancelled
    send_beat(REQ_LOAD_A, 32'd5);
    send_beat(REQ_LOAD_A, 32'd5);
    send_beat(REQ_LOAD_A, 32'd5);
    send_beat(REQ_LOAD_B, 32'd5);
    send_beat(REQ_RUN, 32'h0);
    // all of A cancelled
    send_beat(REQ_LOAD_A, 32'd1);
    send_beat(REQ_LOAD_B, 32'd1);
    send_beat(REQ_LOAD_A, 32'd2);
    send_beat(REQ_LOAD_B, 32'd2);
    send_beat(REQ_RUN, 32'h0);
    // B only
    send_beat(REQ_LOAD_B, 32'd3);
    send_beat(REQ_RUN, 32'h0);
    // B steps past smaller values before the match
    send_beat(REQ_LOAD_B, 32'd3);
    send_beat(REQ_LOAD_A, 32'd10);
    send_beat(REQ_LOAD_B, 32'd10);
    send_beat(REQ_LOAD_B, 32'd20);
    send_beat(REQ_RUN, 32'h0);

    seq_no = 0;
    while (items_sent < 200) begin
      idle_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      if (seq_no == 2)
        load_and_run(DEPTH_A + 2, $urandom_range(0, 6), 1'b0, 1'b1);
      else if (seq_no == 5)
        load_and_run($urandom_range(0, 6), DEPTH_B + 2, 1'b0, 1'b0);
      else
        load_and_run($urandom_range(0, 10), $urandom_range(0, 10),
                     $urandom_range(0, 9) == 0, 1'b0);
      seq_no++;
    end

    idle_on  = 1'b0;
    stall_on = 1'b0;
    while (items_sent < 230)
      load_and_run($urandom_range(0, 8), $urandom_range(0, 8), 1'b0, 1'b0);
    in_tvalid <= 1'b0;

    waited = 0;
    while (sb.pending_diffs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_diffs.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_diffs.size()));
    if (sb.mismatches == 0) begin
      $display("[sorted_multiset_difference_core] OK");
    end else begin
      $display("[sorted_multiset_difference_core] ERROR");
    end
    $finish;
  end

endmodule
